/* design/mme_pkg.sv */
// Shared types, constants and helper functions of the matrix multiply engine.
package mme_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 16;
    localparam int IN_WIDTH   = 16;
    localparam int OUT_WIDTH  = 35;
    localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
    localparam int DIM_W      = 4;
    localparam int FIELD_IDX_W = 3;
    localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

    typedef struct packed {
        logic [1:0]                   cmd;
        logic [FIELD_IDX_W-1:0]       row_index;
        logic [FIELD_IDX_W-1:0]       col_index;
        logic signed [IN_WIDTH-1:0]   element_value;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0]  product_value;
        logic [FIELD_IDX_W-1:0]       out_row;
        logic [FIELD_IDX_W-1:0]       out_col;
        logic                         last;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Tag that follows each multiply-accumulate step down the pipeline.
    typedef struct packed {
        logic                   first;
        logic                   last_k;
        logic [FIELD_IDX_W-1:0] row;
        logic [FIELD_IDX_W-1:0] col;
        logic                   last;
    } t_tag;

    typedef struct packed {
        logic                  wr_a;
        logic                  wr_b;
        logic [ADDR_W-1:0]     wr_addr;
        logic [ELEM_WIDTH-1:0] wr_data;
        logic                  rd_valid;
        logic [ADDR_W-1:0]     a_addr;
        logic [ADDR_W-1:0]     b_addr;
        t_tag                  tag;
    } t_dp_cmd;

    typedef struct packed {
        logic advance;
    } t_dp_status;

    function automatic logic [ADDR_W-1:0] mat_addr(input logic [FIELD_IDX_W-1:0] row,
                                                   input logic [FIELD_IDX_W-1:0] col);
        int lin;
        lin = int'(row) * MAX_DIM + int'(col);
        return ADDR_W'(lin);
    endfunction

    // Sign-extend the 16-bit input value, then keep the element width.
    function automatic logic [ELEM_WIDTH-1:0] elem_from_in(input logic signed [IN_WIDTH-1:0] v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[ELEM_WIDTH-1:0];
    endfunction

    // Bring a product to the accumulator width, wrapping if it is wider.
    function automatic logic signed [OUT_WIDTH-1:0] acc_from_prod(
            input logic signed [PROD_WIDTH-1:0] p);
        logic signed [63:0] wide;
        wide = 64'(p);
        return wide[OUT_WIDTH-1:0];
    endfunction

endpackage

/* design/mme_ram.sv */
// Generic single-write, single-read memory with a registered read port.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/mme_ctrl.sv */
// Controller of the matrix multiply engine: size registers, loop counters and state machine.
module mme_ctrl import mme_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output t_dp_cmd              o_cmd,
    input  t_dp_status           i_status
);

    t_state r_state, n_state;

    logic [DIM_W-1:0] r_rows, r_inner, r_cols;
    logic [IDX_W-1:0] r_i, r_j, r_k;

    logic in_fire, cfg_fire, is_compute, in_range, issue_fire;
    logic k_last, j_last, i_last;
    logic [DIM_W-1:0] cfg_clamped;

    assign in_fire    = i_in_valid && o_in_ready;
    assign cfg_fire   = i_cfg_valid && o_cfg_ready;
    assign is_compute = (i_in_item.cmd == CMD_COMPUTE);
    assign in_range   = (int'(i_in_item.row_index) < MAX_DIM)
                     && (int'(i_in_item.col_index) < MAX_DIM);

    assign k_last = ((DIM_W'(r_k) + DIM_W'(1)) == r_inner);
    assign j_last = ((DIM_W'(r_j) + DIM_W'(1)) == r_cols);
    assign i_last = ((DIM_W'(r_i) + DIM_W'(1)) == r_rows);

    assign issue_fire = (r_state == ST_RUN) && i_status.advance;

    // Out-of-range sizes saturate into 1 .. MAX_DIM.
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = DIM_W'(1);
        end else if (int'(i_cfg_data) > MAX_DIM) begin
            cfg_clamped = DIM_W'(MAX_DIM);
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_W'(MAX_DIM);
            r_inner <= DIM_W'(MAX_DIM);
            r_cols  <= DIM_W'(MAX_DIM);
        end else if (cfg_fire) begin
            case (i_cfg_index)
                REG_ROWS:  r_rows  <= cfg_clamped;
                REG_INNER: r_inner <= cfg_clamped;
                REG_COLS:  r_cols  <= cfg_clamped;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (in_fire && is_compute) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end else if (issue_fire) begin
                if (!k_last) begin
                    r_k <= r_k + IDX_W'(1);
                end else begin
                    r_k <= '0;
                    if (!j_last) begin
                        r_j <= r_j + IDX_W'(1);
                    end else begin
                        r_j <= '0;
                        r_i <= i_last ? '0 : r_i + IDX_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && is_compute) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue_fire && k_last && j_last && i_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_cfg_ready     = 1'b1;
        o_cmd           = '0;
        o_cmd.wr_a      = in_fire && (i_in_item.cmd == CMD_WRITE_A) && in_range;
        o_cmd.wr_b      = in_fire && (i_in_item.cmd == CMD_WRITE_B) && in_range;
        o_cmd.wr_addr   = mat_addr(i_in_item.row_index, i_in_item.col_index);
        o_cmd.wr_data   = elem_from_in(i_in_item.element_value);
        o_cmd.rd_valid  = (r_state == ST_RUN);
        o_cmd.a_addr    = mat_addr(FIELD_IDX_W'(r_i), FIELD_IDX_W'(r_k));
        o_cmd.b_addr    = mat_addr(FIELD_IDX_W'(r_k), FIELD_IDX_W'(r_j));
        o_cmd.tag.first  = (r_k == '0);
        o_cmd.tag.last_k = k_last;
        o_cmd.tag.row    = FIELD_IDX_W'(r_i);
        o_cmd.tag.col    = FIELD_IDX_W'(r_j);
        o_cmd.tag.last   = i_last && j_last;
    end

endmodule

/* design/mme_datapath.sv */
// Datapath of the matrix multiply engine: element memories, multiplier, accumulator, output register.
module mme_datapath import mme_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    logic                         advance;
    logic [ELEM_WIDTH-1:0]        a_rdata, b_rdata;
    logic                         r_s1_valid, r_s2_valid, r_out_valid;
    t_tag                         r_s1_tag, r_s2_tag;
    logic signed [PROD_WIDTH-1:0] r_prod;
    logic signed [OUT_WIDTH-1:0]  r_acc, acc_sum;
    t_out_item                    r_out;

    // The whole pipeline holds while a result waits on a stalled receiver.
    assign advance          = !(r_out_valid && !i_out_ready);
    assign o_status.advance = advance;

    mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_a),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (i_cmd.wr_data),
        .i_re    (i_cmd.rd_valid && advance),
        .i_raddr (i_cmd.a_addr),
        .o_rdata (a_rdata)
    );

    mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_b),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (i_cmd.wr_data),
        .i_re    (i_cmd.rd_valid && advance),
        .i_raddr (i_cmd.b_addr),
        .o_rdata (b_rdata)
    );

    assign acc_sum = (r_s2_tag.first ? '0 : r_acc) + acc_from_prod(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_cmd.rd_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_tag.last_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_tag <= i_cmd.tag;
            r_s2_tag <= r_s1_tag;
            r_prod   <= $signed(a_rdata) * $signed(b_rdata);
            if (r_s2_valid) begin
                if (r_s2_tag.last_k) begin
                    r_out.product_value <= acc_sum;
                    r_out.out_row       <= r_s2_tag.row;
                    r_out.out_col       <= r_s2_tag.col;
                    r_out.last          <= r_s2_tag.last;
                end else begin
                    r_acc <= acc_sum;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* design/matrix_multiply_engine_unit.sv */
// Top level of the matrix multiply engine: controller and datapath joined together.
//
// The engine computes C = A x B for A of rows_used x inner_used and B of
// inner_used x cols_used elements, all signed Q8.8. The host loads elements
// through the input channel, one transaction per element, with a command that
// selects A or B and a row and column index. A compute transaction then makes
// the engine emit every element of C in row-major order as exact Q19.16 values
// on the output channel, with last set on the final element.
// Sizes are set through the configuration channel (index 0 rows, 1 inner,
// 2 cols); out-of-range values saturate into 1 .. 8. Configure only while idle.
// A compute transaction occupies the single multiply-accumulate unit for
// rows_used * cols_used * inner_used products, one product per cycle while the
// receiver does not stall, fed by one read port on each element memory; the
// input channel is not ready during that time. The operands pass the registered
// memory reads, then the product register; a finished element of C sits in the
// output register. When the receiver stalls, the whole pipeline holds in place
// and nothing is lost. Reset returns the sizes to 8 and empties the pipeline;
// the element memories are not cleared and must be written before use.
module matrix_multiply_engine_unit import mme_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The controller walks the row, column and inner loops and issues reads.
    mme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // The datapath stores elements, multiplies, accumulates and holds the result.
    mme_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* design/mme_checker.sv */
// Port-level assertions for the matrix multiply engine and their bind.
module mme_checker import mme_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t_in_item             i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_item            o_out_item
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    // A reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An accepted compute leaves the input not ready in the cycle after it.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.cmd == CMD_COMPUTE) |=> !o_in_ready)
        else $error("input still ready after compute");

    // An element write never makes the engine busy.
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.cmd != CMD_COMPUTE) |=> o_in_ready)
        else $error("input not ready after element write");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (.*);

/* dv/mme_product_check_pkg.sv */
// Scoreboard class for the matrix multiply engine testbench.
package mme_product_check_pkg;
    import mme_pkg::*;

    class product_scoreboard;
        // Only the first PRINT_CAP mismatches are printed; all of them are counted.
        localparam int unsigned PRINT_CAP = 40;

        int unsigned rows;
        int unsigned inner;
        int unsigned cols;
        logic signed [ELEM_WIDTH-1:0] mat_a [DEPTH];
        logic signed [ELEM_WIDTH-1:0] mat_b [DEPTH];
        t_out_item expected_products [$];
        int unsigned writes;
        int unsigned computes;
        int unsigned ignored;
        int unsigned checked;
        int unsigned errors;

        function new();
            rows  = MAX_DIM;
            inner = MAX_DIM;
            cols  = MAX_DIM;
            foreach (mat_a[n]) begin
                mat_a[n] = '0;
                mat_b[n] = '0;
            end
            writes   = 0;
            computes = 0;
            ignored  = 0;
            checked  = 0;
            errors   = 0;
        endfunction

        // Size registers saturate into 1 .. MAX_DIM.
        function int unsigned saturate_dim(logic [DIM_W-1:0] value);
            if (value == 0) return 1;
            if (value > MAX_DIM) return MAX_DIM;
            return int'(value);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] index, logic [DIM_W-1:0] value);
            case (index)
                REG_ROWS:  rows  = saturate_dim(value);
                REG_INNER: inner = saturate_dim(value);
                REG_COLS:  cols  = saturate_dim(value);
                default: ;
            endcase
        endfunction

        // Every element of C in row-major order, each an exact sum of products.
        function void predict_products();
            longint    sum;
            t_out_item want;
            for (int i = 0; i < rows; i++) begin
                for (int j = 0; j < cols; j++) begin
                    sum = 0;
                    for (int k = 0; k < inner; k++) begin
                        sum += longint'(mat_a[i * MAX_DIM + k]) *
                               longint'(mat_b[k * MAX_DIM + j]);
                    end
                    want.product_value = sum[OUT_WIDTH-1:0];
                    want.out_row       = FIELD_IDX_W'(i);
                    want.out_col       = FIELD_IDX_W'(j);
                    want.last          = (i == rows - 1) && (j == cols - 1);
                    expected_products.push_back(want);
                end
            end
        endfunction

        function void note_input(t_in_item item);
            int unsigned slot;
            slot = int'(item.row_index) * MAX_DIM + int'(item.col_index);
            case (item.cmd)
                CMD_WRITE_A: begin
                    mat_a[slot] = ELEM_WIDTH'(longint'(item.element_value));
                    writes++;
                end
                CMD_WRITE_B: begin
                    mat_b[slot] = ELEM_WIDTH'(longint'(item.element_value));
                    writes++;
                end
                CMD_COMPUTE: begin
                    predict_products();
                    computes++;
                end
                default: ignored++;
            endcase
        endfunction

        function int unsigned pending();
            return expected_products.size();
        endfunction

        task report_mismatch(string text);
            if (errors < PRINT_CAP) $display("MISMATCH: %s", text);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_products.size() == 0) begin
                report_mismatch($sformatf("product element row %0d col %0d with none expected",
                                          got.out_row, got.out_col));
                return;
            end
            want = expected_products.pop_front();
            checked++;
            if (got.product_value !== want.product_value)
                report_mismatch($sformatf("C[%0d][%0d] value %0d, expected %0d",
                                          want.out_row, want.out_col,
                                          got.product_value, want.product_value));
            if (got.out_row !== want.out_row)
                report_mismatch($sformatf("row %0d, expected %0d", got.out_row, want.out_row));
            if (got.out_col !== want.out_col)
                report_mismatch($sformatf("col %0d, expected %0d", got.out_col, want.out_col));
            if (got.last !== want.last)
                report_mismatch($sformatf("C[%0d][%0d] last %b, expected %b",
                                          want.out_row, want.out_col, got.last, want.last));
        endtask

        task flag_leftovers();
            if (expected_products.size() != 0)
                report_mismatch($sformatf("%0d product elements never arrived",
                                          expected_products.size()));
        endtask
    endclass

endpackage

/* dv/matrix_multiply_engine_unit_test.sv */
// Self-checking testbench of the matrix multiply engine top level.
module matrix_multiply_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;
    import mme_product_check_pkg::*;

    // Command and register codes that the package does not name.
    localparam logic [1:0]           CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

    localparam int NUM_PHASES    = 9;
    localparam int PHASE_ITEMS   = 40;
    localparam int DRAIN_LIMIT   = 100000;
    // Settle time after the last product element, so that the block is idle before the sizes change.
    localparam int SETTLE_CYCLES = 2 * MAX_DIM + 4;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    product_scoreboard sb;

    // Percentage of cycles in which the sender or the receiver holds back.
    int unsigned in_idle_pct;
    int unsigned out_idle_pct;

    // Input transactions of the current phase, unused commands left out.
    int unsigned phase_items;
    int unsigned size_settings;

    // Which element memory entries hold a value. A compute must never read an
    // entry that was not written since reset, so operands are loaded first.
    bit a_loaded [DEPTH];
    bit b_loaded [DEPTH];

    matrix_multiply_engine_unit DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog. Even with every transaction a full 8x8x8 compute and the
    // receiver stalling most cycles, a correct run ends far earlier.
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: the ready and valid values seen just after the edge are the
    // ones that the edge sampled, so a product element counts as accepted here
    // exactly when the block saw the handshake. The ready for the next edge is
    // then rolled against the current stall percentage.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Drives one input transaction and waits until the block takes it. Valid
    // stays high on return so that a back-to-back transaction needs no toggle;
    // the caller drops it when the stream pauses.
    task automatic send_item(input t_in_item item);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(item);
        if (item.cmd != CMD_UNUSED) phase_items++;
    endtask

    task automatic write_elem(input logic [1:0] cmd, input int row, input int col,
                              input logic signed [IN_WIDTH-1:0] value);
        t_in_item item;
        item.cmd           = cmd;
        item.row_index     = FIELD_IDX_W'(row);
        item.col_index     = FIELD_IDX_W'(col);
        item.element_value = value;
        send_item(item);
        if (cmd == CMD_WRITE_A) a_loaded[row * MAX_DIM + col] = 1'b1;
        else b_loaded[row * MAX_DIM + col] = 1'b1;
    endtask

    // Element values lean on the Q8.8 extremes and zero.
    function automatic logic signed [IN_WIDTH-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 16'sh8000;
        if (roll < 20) return 16'sh7FFF;
        if (roll < 25) return '0;
        return IN_WIDTH'($urandom);
    endfunction

    // Size register values, now and then outside 1 .. MAX_DIM to hit saturation.
    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(0, 9) == 0) return DIM_W'($urandom_range(0, 15));
        return DIM_W'($urandom_range(1, MAX_DIM));
    endfunction

    // Writes every operand entry that the next compute reads and that was
    // never written, so that the compute is well formed.
    task automatic load_operands();
        for (int i = 0; i < sb.rows; i++)
            for (int k = 0; k < sb.inner; k++)
                if (!a_loaded[i * MAX_DIM + k]) write_elem(CMD_WRITE_A, i, k, pick_value());
        for (int k = 0; k < sb.inner; k++)
            for (int j = 0; j < sb.cols; j++)
                if (!b_loaded[k * MAX_DIM + j]) write_elem(CMD_WRITE_B, k, j, pick_value());
    endtask

    // Compute transaction; its index and value fields are ignored by the
    // block, so they carry random bits.
    task automatic run_compute();
        t_in_item item;
        load_operands();
        item.cmd           = CMD_COMPUTE;
        item.row_index     = FIELD_IDX_W'($urandom_range(0, MAX_DIM - 1));
        item.col_index     = FIELD_IDX_W'($urandom_range(0, MAX_DIM - 1));
        item.element_value = IN_WIDTH'($urandom);
        send_item(item);
    endtask

    // The unused command code must produce nothing.
    task automatic send_noise();
        t_in_item item;
        item.cmd           = CMD_UNUSED;
        item.row_index     = FIELD_IDX_W'($urandom_range(0, MAX_DIM - 1));
        item.col_index     = FIELD_IDX_W'($urandom_range(0, MAX_DIM - 1));
        item.element_value = IN_WIDTH'($urandom);
        send_item(item);
    endtask

    // One random transaction: mostly element writes into the region that the
    // current sizes use, some writes anywhere, computes and a little noise.
    task automatic random_item();
        int unsigned roll;
        logic [1:0]  cmd;
        int          row;
        int          col;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            run_compute();
        end else if (roll < 13) begin
            send_noise();
        end else begin
            cmd = $urandom_range(0, 1) ? CMD_WRITE_B : CMD_WRITE_A;
            if ($urandom_range(0, 3) != 0) begin
                if (cmd == CMD_WRITE_A) begin
                    row = $urandom_range(0, sb.rows - 1);
                    col = $urandom_range(0, sb.inner - 1);
                end else begin
                    row = $urandom_range(0, sb.inner - 1);
                    col = $urandom_range(0, sb.cols - 1);
                end
            end else begin
                row = $urandom_range(0, MAX_DIM - 1);
                col = $urandom_range(0, MAX_DIM - 1);
            end
            write_elem(cmd, row, col, pick_value());
        end
    endtask

    // Register write; valid stays high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(index, data);
    endtask

    task automatic set_sizes(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                             input logic [DIM_W-1:0] cols);
        write_reg(REG_ROWS, rows);
        write_reg(REG_INNER, inner);
        write_reg(REG_COLS, cols);
        i_cfg_valid <= 1'b0;
        size_settings++;
    endtask

    // Waits until every predicted product element has been taken, then lets
    // the pipeline settle so the block is idle before the sizes change.
    task automatic drain();
        int unsigned waited;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        in_idle_pct   = 0;
        out_idle_pct  = 0;
        phase_items   = 0;
        size_settings = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Smallest sizes first, plus a write to the spare
        // register index, which the block must ignore.
        write_reg(REG_ROWS, 4'd1);
        write_reg(REG_INNER, 4'd1);
        write_reg(REG_COLS, 4'd1);
        write_reg(REG_SPARE, 4'd5);
        i_cfg_valid <= 1'b0;
        size_settings++;

        // Most negative times most negative gives the largest single product,
        // then most positive times most negative the smallest.
        write_elem(CMD_WRITE_A, 0, 0, 16'sh8000);
        write_elem(CMD_WRITE_B, 0, 0, 16'sh8000);
        run_compute();
        write_elem(CMD_WRITE_A, 0, 0, 16'sh7FFF);
        run_compute();
        send_noise();

        // Writes outside the configured sizes are stored but must not change
        // the product.
        write_elem(CMD_WRITE_A, 7, 7, 16'sh1234);
        write_elem(CMD_WRITE_B, 5, 2, -16'sd1);
        write_elem(CMD_WRITE_A, 0, 1, 16'sh7FFF);
        run_compute();
        i_in_valid <= 1'b0;
        drain();

        // Out-of-range sizes: 9 and 15 saturate to 8, 0 to 1. The compute
        // then emits the largest number of product elements.
        set_sizes(4'd9, 4'd0, 4'd15);
        run_compute();
        i_in_valid <= 1'b0;
        drain();

        // Random phases. The receiver idles first, then the sender, and the
        // last three phases run at full rate on both sides.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p / 3)
                0: begin
                    in_idle_pct  = 24;
                    out_idle_pct = 65;
                end
                1: begin
                    in_idle_pct  = 65;
                    out_idle_pct = 24;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            case (p)
                0, 7:    set_sizes(4'd8, 4'd8, 4'd8);
                1:       set_sizes(4'd1, 4'd1, 4'd1);
                3:       set_sizes(4'd1, 4'd8, 4'd1);
                4:       set_sizes(4'd8, 4'd1, 4'd8);
                default: set_sizes(pick_dim(), pick_dim(), pick_dim());
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) random_item();
            run_compute();
            i_in_valid <= 1'b0;
            drain();
        end

        sb.flag_leftovers();
        $display("summary: %0d element writes, %0d computes, %0d ignored commands accepted",
                 sb.writes, sb.computes, sb.ignored);
        $display("summary: %0d product elements checked over %0d size settings, %0d mismatches",
                 sb.checked, size_settings, sb.errors);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/mme_pkg.sv
design/mme_ram.sv
design/mme_ctrl.sv
design/mme_datapath.sv
design/matrix_multiply_engine_unit.sv
design/mme_checker.sv
dv/mme_product_check_pkg.sv
dv/matrix_multiply_engine_unit_test.sv
